>>> hw/rtl/wsg_pkg.sv
// Shared types, constants and helper functions of the wavetable sound generator.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package wsg_pkg;

    // Command codes carried by the func field of a transaction.
    typedef enum logic [1:0] {
        FN_REG_WR  = 2'd0,
        FN_WAVE_WR = 2'd1,
        FN_TICK    = 2'd2,
        FN_EN_WR   = 2'd3
    } t_func;

    // Configuration register indexes on the APB port.
    localparam logic [1:0] CFG_VOICE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LAYOUT      = 2'd1;
    localparam logic [1:0] CFG_TWO_SPB     = 2'd2;

    // Field and datapath widths.
    localparam int STEP_W = 20;           // phase accumulator and frequency
    localparam int LVL_W  = 4;            // voice volume
    localparam int SEL_W  = 3;            // wave select
    localparam int SUM_W  = 11;           // signed sum of up to eight voice products
    localparam int MAG_W  = SUM_W - 1;    // magnitude of that sum
    localparam int DIVD_W = MAG_W + 8;    // magnitude scaled by 256
    localparam int OUT_W  = 16;           // output sample
    localparam logic [14:0] SAT_MAX = 15'h7fff;

    // Register file decode sequencer states.
    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_RUN,
        DEC_DRAIN
    } t_dec_state;

    // Voice accumulation sequencer states.
    typedef enum logic [1:0] {
        VOX_IDLE,
        VOX_RUN,
        VOX_DRAIN
    } t_vox_state;

    // Scaling divider states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_OUT
    } t_div_state;

    // Decoded voice parameters written from the register decoder to the voice engine.
    typedef struct packed {
        logic              we;
        logic [2:0]        voice;
        logic [STEP_W-1:0] step;
        logic [LVL_W-1:0]  level;
        logic [SEL_W-1:0]  sel;
    } t_voice_wr;

    // Register file address of one decode step of one voice.
    function automatic logic [5:0] dec_addr(input logic layout, input logic [2:0] voice,
                                            input logic [2:0] step);
        logic [5:0] base;
        logic [5:0] off;
        if (layout) begin
            // Byte layout: level, then high/wave byte, then middle and low frequency bytes.
            base = {voice, 3'b000};
            unique case (step)
                3'd0:    off = 6'h03;
                3'd1:    off = 6'h06;
                3'd2:    off = 6'h05;
                default: off = 6'h04;
            endcase
        end else begin
            // Nibble layout: four or five frequency nibbles, then level and wave select.
            base = {1'b0, voice, 2'b00} + {3'b000, voice};
            unique case (step)
                3'd0:    off = 6'h14;
                3'd1:    off = 6'h13;
                3'd2:    off = 6'h12;
                3'd3:    off = 6'h11;
                3'd4:    off = 6'h10;
                3'd5:    off = 6'h15;
                default: off = 6'h05;
            endcase
        end
        return base + off;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wsg_regs.sv
// Register file memory and the voice decode sequencer that reads it one byte per cycle.
// Depends on wsg_pkg; feeds decoded voice parameters to wsg_voice.
`default_nettype none

module wsg_regs #(
    parameter int REG_BYTES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [7:0]        i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_layout,
    input  wire logic [3:0]        i_nvoc,
    output wsg_pkg::t_voice_wr     o_voice_wr,
    output logic                   o_busy
);
    import wsg_pkg::*;

    localparam int RAW = $clog2(REG_BYTES);

    t_dec_state r_state, n_state;
    logic [2:0] r_voice, n_voice;
    logic [2:0] r_step, n_step;

    logic [7:0]           r_mem [REG_BYTES];
    logic [REG_BYTES-1:0] r_rvalid;
    logic [7:0]           r_rdata;
    logic                 r_rd_ok;

    logic       r_tag_vld;
    logic       r_tag_last;
    logic [2:0] r_tag_step;
    logic [2:0] r_tag_voice;

    logic [STEP_W-1:0] r_acc, n_acc;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [SEL_W-1:0]  r_sel, n_sel;

    logic [5:0]        w_wr_idx;
    logic              w_wr_ok;
    logic [5:0]        w_rd_addr;
    logic              w_rd_ok;
    logic              w_issue;
    logic [3:0]        w_ndec;
    logic [2:0]        w_last_step;
    logic              w_last_voice;
    logic [7:0]        w_byte;
    logic [STEP_W-1:0] w_base;
    logic              w_sh8;
    logic [7:0]        w_add;
    logic              w_use_unit;
    logic [STEP_W-1:0] w_unit;

    function automatic logic [7:0] i_wr_layout_data(input logic layout, input logic [7:0] d);
        return layout ? d : {4'b0000, d[3:0]};
    endfunction

    // Number of voices decoded and the step count per voice for the current layout.
    assign w_ndec       = i_layout ? i_nvoc : ((i_nvoc > 4'd3) ? 4'd3 : i_nvoc);
    assign w_last_step  = i_layout ? 3'd3 : 3'd6;
    assign w_last_voice = ({1'b0, r_voice} == (w_ndec - 4'd1));

    // Register file write; offsets beyond the file are dropped.
    assign w_wr_idx = i_wr_addr[5:0];
    assign w_wr_ok  = i_wr_en && ({1'b0, w_wr_idx} < 7'(REG_BYTES));

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[w_wr_idx[RAW-1:0]] <= i_wr_layout_data(i_layout, i_wr_data);
        end
        r_rdata <= r_mem[w_rd_addr[RAW-1:0]];
    end

    // Per-entry valid bits make never-written entries read as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (w_wr_ok) begin
                r_rvalid[w_wr_idx[RAW-1:0]] <= 1'b1;
            end
            r_rd_ok <= w_rd_ok && r_rvalid[w_rd_addr[RAW-1:0]];
        end
    end

    assign w_rd_addr = dec_addr(i_layout, r_voice, r_step);
    assign w_rd_ok   = ({1'b0, w_rd_addr} < 7'(REG_BYTES));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= DEC_IDLE;
            r_voice   <= '0;
            r_step    <= '0;
            r_tag_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_voice   <= n_voice;
            r_step    <= n_step;
            r_tag_vld <= w_issue;
        end
    end

    // Sequencer: one register read issued per cycle, voice by voice.
    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_step  = r_step;
        w_issue = 1'b0;
        unique case (r_state)
            DEC_IDLE: begin
                if (i_wr_en) begin
                    n_voice = '0;
                    n_step  = '0;
                    n_state = (w_ndec == 4'd0) ? DEC_IDLE : DEC_RUN;
                end
            end
            DEC_RUN: begin
                w_issue = 1'b1;
                if (r_step == w_last_step) begin
                    n_step = '0;
                    if (w_last_voice) begin
                        n_state = DEC_DRAIN;
                    end else begin
                        n_voice = r_voice + 3'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            DEC_DRAIN: begin
                n_state = DEC_IDLE;
            end
            default: begin
                n_state = DEC_IDLE;
            end
        endcase
    end

    // Tags travel with the registered read data.
    always_ff @(posedge i_clk) begin
        r_tag_step  <= r_step;
        r_tag_voice <= r_voice;
        r_tag_last  <= (r_step == w_last_step);
        if (r_tag_vld) begin
            r_acc <= n_acc;
            r_lvl <= n_lvl;
            r_sel <= n_sel;
        end
    end

    assign w_byte = r_rd_ok ? r_rdata : 8'h00;

    // Shared shift-and-add unit assembles the frequency from bytes or nibbles.
    assign w_unit = (w_sh8 ? {w_base[STEP_W-9:0], 8'h00} : {w_base[STEP_W-5:0], 4'h0})
                    + {12'h000, w_add};

    always_comb begin
        w_base     = r_acc;
        w_sh8      = 1'b0;
        w_add      = w_byte;
        w_use_unit = 1'b0;
        n_lvl      = r_lvl;
        n_sel      = r_sel;
        if (i_layout) begin
            unique case (r_tag_step)
                3'd0: n_lvl = w_byte[3:0];
                3'd1: begin
                    w_base     = '0;
                    w_add      = {4'h0, w_byte[3:0]};
                    w_use_unit = 1'b1;
                    n_sel      = w_byte[6:4];
                end
                default: begin
                    w_sh8      = 1'b1;
                    w_use_unit = 1'b1;
                end
            endcase
        end else begin
            unique case (r_tag_step)
                3'd0: begin
                    w_base     = '0;
                    w_use_unit = 1'b1;
                end
                3'd4: begin
                    // Only voice 0 has a fifth, lowest nibble; the others shift in zero.
                    w_add      = (r_tag_voice == 3'd0) ? w_byte : 8'h00;
                    w_use_unit = 1'b1;
                end
                3'd5:    n_lvl = w_byte[3:0];
                3'd6:    n_sel = w_byte[2:0];
                default: w_use_unit = 1'b1;
            endcase
        end
        n_acc = w_use_unit ? w_unit : r_acc;
    end

    // Voice write on the last step of each voice.
    always_comb begin
        o_voice_wr.we    = r_tag_vld && r_tag_last;
        o_voice_wr.voice = r_tag_voice;
        o_voice_wr.step  = n_acc;
        o_voice_wr.level = n_lvl;
        o_voice_wr.sel   = n_sel;
    end

    assign o_busy = (r_state != DEC_IDLE);

    // A voice is written only while a decode pass runs.
    a_wr_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_voice_wr.we |-> o_busy)
        else $error("voice write outside a decode pass");

    // Read tags appear only in the cycle after an issue in the run state.
    a_tag_follows_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_vld |-> ($past(r_state) == DEC_RUN))
        else $error("read tag without an issuing cycle");

    // A decode pass never starts unless a register write was accepted.
    a_start_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DEC_IDLE && !i_wr_en) |=> (r_state == DEC_IDLE))
        else $error("decode pass started without a register write");

endmodule

`default_nettype wire

>>> hw/rtl/wsg_voice.sv
// Voice state, wave memory and the per-voice phase/sample/product accumulation loop.
// Depends on wsg_pkg; receives decoded parameters from wsg_regs, feeds wsg_div.
`default_nettype none

module wsg_voice #(
    parameter int VOICES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire wsg_pkg::t_voice_wr          i_voice_wr,
    input  wire logic                        i_wave_we,
    input  wire logic [7:0]                  i_wave_addr,
    input  wire logic [7:0]                  i_wave_data,
    input  wire logic                        i_tick,
    input  wire logic                        i_sound_on,
    input  wire logic                        i_two,
    input  wire logic [3:0]                  i_nvoc,
    output logic                             o_done,
    output logic signed [wsg_pkg::SUM_W-1:0] o_sum,
    output logic                             o_busy
);
    import wsg_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_vox_state r_state, n_state;
    logic [2:0] r_voice, n_voice;

    logic [STEP_W-1:0] r_phase [VOICES];
    logic [STEP_W-1:0] r_step  [VOICES];
    logic [LVL_W-1:0]  r_level [VOICES];
    logic [SEL_W-1:0]  r_sel   [VOICES];

    logic [7:0] r_wave [256];
    logic [7:0] r_wdata;

    logic             r_t_vld;
    logic             r_t_odd;
    logic [LVL_W-1:0] r_t_lvl;

    logic signed [SUM_W-1:0] r_sum, n_sum;

    logic [VW-1:0]      w_vi;
    logic [STEP_W-1:0]  w_stp;
    logic [LVL_W-1:0]   w_lvl;
    logic [SEL_W-1:0]   w_sel;
    logic               w_active;
    logic               w_issue;
    logic [STEP_W-1:0]  w_phase_nx;
    logic [4:0]         w_idx;
    logic [7:0]         w_waddr;
    logic [3:0]         w_nib;
    logic signed [4:0]  w_cent;
    logic signed [4:0]  w_lvl_s;
    logic signed [9:0]  w_prod;
    logic signed [SUM_W-1:0] w_add;
    logic               w_last_voice;

    // Selected voice and its next phase.
    assign w_vi         = r_voice[VW-1:0];
    assign w_stp        = r_step[w_vi];
    assign w_lvl        = r_level[w_vi];
    assign w_sel        = r_sel[w_vi];
    assign w_active     = (w_lvl != '0) && (w_stp != '0);
    assign w_phase_nx   = r_phase[w_vi] + w_stp;
    assign w_idx        = w_phase_nx[STEP_W-1:STEP_W-5];
    assign w_waddr      = i_two ? {w_sel, 1'b0, w_idx[4:1]} : {w_sel, w_idx};
    assign w_last_voice = ({1'b0, r_voice} == (i_nvoc - 4'd1));

    // Voice parameter and phase storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
                r_step[v]  <= '0;
                r_level[v] <= '0;
                r_sel[v]   <= '0;
            end
        end else begin
            if (i_voice_wr.we) begin
                r_step[i_voice_wr.voice[VW-1:0]]  <= i_voice_wr.step;
                r_level[i_voice_wr.voice[VW-1:0]] <= i_voice_wr.level;
                r_sel[i_voice_wr.voice[VW-1:0]]   <= i_voice_wr.sel;
            end
            if (w_issue && w_active) begin
                r_phase[w_vi] <= w_phase_nx;
            end
        end
    end

    // Wave memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_wave_we) begin
            r_wave[i_wave_addr] <= i_wave_data;
        end
        r_wdata <= r_wave[w_waddr];
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= VOX_IDLE;
            r_voice <= '0;
            r_t_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_t_vld <= w_issue && w_active;
        end
    end

    // Sequencer: one voice issued per cycle; a silent tick goes straight to the drain state.
    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        w_issue = 1'b0;
        unique case (r_state)
            VOX_IDLE: begin
                if (i_tick) begin
                    n_voice = '0;
                    n_state = (!i_sound_on || i_nvoc == 4'd0) ? VOX_DRAIN : VOX_RUN;
                end
            end
            VOX_RUN: begin
                w_issue = 1'b1;
                if (w_last_voice) begin
                    n_state = VOX_DRAIN;
                end else begin
                    n_voice = r_voice + 3'd1;
                end
            end
            VOX_DRAIN: begin
                n_state = VOX_IDLE;
            end
            default: begin
                n_state = VOX_IDLE;
            end
        endcase
    end

    // Sample pick, centering and volume product on the registered wave byte.
    always_ff @(posedge i_clk) begin
        r_t_odd <= w_idx[0];
        r_t_lvl <= w_lvl;
        if (r_state == VOX_IDLE && i_tick) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        if (i_two) begin
            w_nib = r_t_odd ? r_wdata[3:0] : r_wdata[7:4];
        end else begin
            w_nib = r_wdata[3:0];
        end
        w_cent  = $signed({1'b0, w_nib}) - 5'sd8;
        w_lvl_s = $signed({1'b0, r_t_lvl});
        w_prod  = w_cent * w_lvl_s;
        if (r_t_vld) begin
            w_add = SUM_W'(w_prod);
        end else begin
            w_add = '0;
        end
        n_sum = r_sum + w_add;
    end

    assign o_done = (r_state == VOX_DRAIN);
    assign o_sum  = n_sum;
    assign o_busy = (r_state != VOX_IDLE);

    // Phases move only during the voice loop.
    a_phase_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != VOX_RUN) |=> $stable(r_phase[0]))
        else $error("phase changed outside the voice loop");

    // A tick with sound off finishes without visiting the voice loop.
    a_silent_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == VOX_IDLE && i_tick && !i_sound_on) |=> (r_state == VOX_DRAIN))
        else $error("silent tick entered the voice loop");

    // Decode writes and the voice loop never overlap.
    a_no_wr_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_voice_wr.we |-> (r_state == VOX_IDLE))
        else $error("voice parameters written during a tick");

endmodule

`default_nettype wire

>>> hw/rtl/wsg_div.sv
// Output scaling: |sum| * 256 / voice count by a one-bit-per-cycle restoring divider,
// then saturation and sign. Depends on wsg_pkg.
`default_nettype none

module wsg_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_go,
    input  wire logic signed [wsg_pkg::SUM_W-1:0]   i_sum,
    input  wire logic [3:0]                         i_nvoc,
    output logic                                    o_strobe,
    output logic signed [wsg_pkg::OUT_W-1:0]        o_sample,
    output logic                                    o_busy
);
    import wsg_pkg::*;

    t_div_state r_state, n_state;

    logic [DIVD_W-1:0]      r_q;
    logic [3:0]             r_rem;
    logic [4:0]             r_cnt;
    logic                   r_neg;
    logic                   r_zero;
    logic                   r_strobe;
    logic signed [OUT_W-1:0] r_sample;

    logic [SUM_W-1:0] w_abs;
    logic [4:0]       w_trial;
    logic             w_ge;
    logic [4:0]       w_diff;
    logic [3:0]       w_rem_nx;
    logic [14:0]      w_mag;
    logic [OUT_W-1:0] w_res;

    assign w_abs    = i_sum[SUM_W-1] ? (-i_sum) : i_sum;
    assign w_trial  = {r_rem, r_q[DIVD_W-1]};
    assign w_ge     = (w_trial >= {1'b0, i_nvoc});
    assign w_diff   = w_trial - {1'b0, i_nvoc};
    assign w_rem_nx = w_ge ? w_diff[3:0] : w_trial[3:0];

    // Saturate the quotient and apply the sign of the sum.
    assign w_mag = (r_q > DIVD_W'(SAT_MAX)) ? SAT_MAX : r_q[14:0];
    always_comb begin
        if (r_zero) begin
            w_res = '0;
        end else if (r_neg) begin
            w_res = -{1'b0, w_mag};
        end else begin
            w_res = {1'b0, w_mag};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DIV_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == DIV_OUT);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_go) n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == 5'(DIVD_W - 1)) n_state = DIV_OUT;
            DIV_OUT:  n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    // Datapath: load, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DIV_IDLE: begin
                r_q    <= {w_abs[MAG_W-1:0], 8'h00};
                r_rem  <= '0;
                r_cnt  <= '0;
                r_neg  <= i_sum[SUM_W-1];
                r_zero <= (i_sum == '0);
            end
            DIV_RUN: begin
                r_q   <= {r_q[DIVD_W-2:0], w_ge};
                r_rem <= w_rem_nx;
                r_cnt <= r_cnt + 5'd1;
            end
            DIV_OUT: begin
                r_sample <= w_res;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_sample = r_sample;
    assign o_busy   = (r_state != DIV_IDLE);

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN && i_nvoc != 4'd0) |-> (r_rem < i_nvoc))
        else $error("divider remainder out of range");

    // A new division is only started from idle.
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (r_state == DIV_IDLE))
        else $error("division started while busy");

    // The strobe is raised in the cycle after the output state.
    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_OUT) |=> r_strobe)
        else $error("missing result strobe");

endmodule

`default_nettype wire

>>> hw/rtl/wavetable_sound_generator_core.sv
// Top level of the wavetable sound generator: command port, APB configuration, submodules.
// Depends on wsg_pkg, wsg_regs, wsg_voice and wsg_div.
// A tick runs the voice loop over the configured voices (skipped when silent) on the shared
// phase adder, closes the sum in the drain state, then divides and saturates before the strobe.
// Busy drops in the strobe cycle, so a new tick is taken no earlier than the last one's strobe.
// A register write keeps busy while its decode pass runs (at most three voices in nibble layout),
// one register file read per cycle; wave and enable writes never assert busy.
// Synchronous active-low reset clears control state, registers, voices and enable (set to on).
`default_nettype none

module wavetable_sound_generator_core #(
    parameter int VOICES    = 8,
    parameter int REG_BYTES = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_func,
    input  wire logic [7:0]                   i_addr,
    input  wire logic [7:0]                   i_data,
    output logic                              o_strobe,
    output logic signed [wsg_pkg::OUT_W-1:0]  o_sample,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import wsg_pkg::*;

    logic [3:0] r_voice_count;
    logic       r_layout;
    logic       r_two;
    logic       r_sound_on;

    logic       w_accept;
    t_func      w_func;
    logic       w_cfg_wr;
    logic [3:0] w_nvoc;
    t_voice_wr  w_voice_wr;
    logic       w_dec_busy;
    logic       w_vox_busy;
    logic       w_div_busy;
    logic       w_vox_done;
    logic signed [SUM_W-1:0] w_sum;

    assign w_accept = start && !busy;
    assign w_func   = t_func'(i_func);
    assign w_nvoc   = (r_voice_count > 4'(VOICES)) ? 4'(VOICES) : r_voice_count;

    // Configuration registers on the APB port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_count <= 4'd8;
            r_layout      <= 1'b0;
            r_two         <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                CFG_VOICE_COUNT: r_voice_count <= pwdata[3:0];
                CFG_LAYOUT:      r_layout      <= pwdata[0];
                CFG_TWO_SPB:     r_two         <= pwdata[0];
                default:         r_two         <= r_two;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_VOICE_COUNT: prdata = {28'h0, r_voice_count};
            CFG_LAYOUT:      prdata = {31'h0, r_layout};
            CFG_TWO_SPB:     prdata = {31'h0, r_two};
            default:         prdata = '0;
        endcase
    end

    // Sound enable transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_on <= 1'b1;
        end else if (w_accept && w_func == FN_EN_WR) begin
            r_sound_on <= (i_data != 8'h00);
        end
    end

    // Register file and voice decode.
    wsg_regs #(
        .REG_BYTES (REG_BYTES)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_accept && w_func == FN_REG_WR),
        .i_wr_addr  (i_addr),
        .i_wr_data  (i_data),
        .i_layout   (r_layout),
        .i_nvoc     (w_nvoc),
        .o_voice_wr (w_voice_wr),
        .o_busy     (w_dec_busy)
    );

    // Voice loop and wave memory.
    wsg_voice #(
        .VOICES (VOICES)
    ) u_voice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_voice_wr  (w_voice_wr),
        .i_wave_we   (w_accept && w_func == FN_WAVE_WR),
        .i_wave_addr (i_addr),
        .i_wave_data (i_data),
        .i_tick      (w_accept && w_func == FN_TICK),
        .i_sound_on  (r_sound_on),
        .i_two       (r_two),
        .i_nvoc      (w_nvoc),
        .o_done      (w_vox_done),
        .o_sum       (w_sum),
        .o_busy      (w_vox_busy)
    );

    // Output scaling.
    wsg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_vox_done),
        .i_sum    (w_sum),
        .i_nvoc   (w_nvoc),
        .o_strobe (o_strobe),
        .o_sample (o_sample),
        .o_busy   (w_div_busy)
    );

    assign busy = w_dec_busy || w_vox_busy || w_div_busy;

    // A result is only delivered once all work has finished.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result delivered while busy");

    // An accepted tick always keeps the block busy in the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FN_TICK) |=> busy)
        else $error("tick accepted but block not busy");

    // Wave and enable transactions complete in the accepting cycle.
    a_short_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == FN_WAVE_WR || w_func == FN_EN_WR)) |=> !busy)
        else $error("single-cycle transaction left the block busy");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for wavetable_sound_generator_core: drives commands and APB settings,
// predicts every mixed sample from its own copy of the voice state. Depends on wsg_pkg and the core.

module tb;
    import wsg_pkg::*;

    localparam int VOICE_SLOTS   = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 100;

    // Predicts the sample of every tick and holds the samples still to come.
    class mix_scoreboard;
        logic [3:0]         voice_count;
        logic               layout;
        logic               two_spb;
        logic [7:0]         regs [64];
        logic [7:0]         wave [256];
        logic [19:0]        phase [VOICE_SLOTS];
        logic [19:0]        step [VOICE_SLOTS];
        logic [3:0]         level [VOICE_SLOTS];
        logic [2:0]         sel [VOICE_SLOTS];
        logic               sound_on;
        logic signed [15:0] expected_samples [$];
        int                 errors;
        int                 n_items;
        int                 n_checked;

        function new();
            voice_count = 4'd8;
            layout      = 1'b0;
            two_spb     = 1'b0;
            sound_on    = 1'b1;
            foreach (regs[i]) regs[i] = 8'h00;
            foreach (wave[i]) wave[i] = 8'h00;
            for (int v = 0; v < VOICE_SLOTS; v++) begin
                phase[v] = '0;
                step[v]  = '0;
                level[v] = '0;
                sel[v]   = '0;
            end
            errors    = 0;
            n_items   = 0;
            n_checked = 0;
        endfunction

        // A completed APB write updates the shadow settings.
        function void write_setting(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_VOICE_COUNT: voice_count = value[3:0];
                CFG_LAYOUT:      layout = value[0];
                CFG_TWO_SPB:     two_spb = value[0];
                default: ;
            endcase
        endfunction

        // Apply one accepted command transaction; a tick queues its sample.
        function void note_command(t_func fn, logic [7:0] addr, logic [7:0] data);
            int unsigned n;
            int unsigned b;
            int unsigned f;
            int unsigned mag;
            int          sum;
            int          res;
            int          v;
            logic [4:0]  idx;
            logic [7:0]  wbyte;
            logic [3:0]  nib;
            n_items++;
            n = (voice_count > VOICE_SLOTS) ? VOICE_SLOTS : voice_count;
            case (fn)
                FN_REG_WR: begin
                    regs[addr[5:0]] = layout ? data : {4'h0, data[3:0]};
                    if (!layout) begin
                        // Nibble layout: at most three voices, frequency built nibble by nibble.
                        for (v = 0; v < 3 && v < n; v++) begin
                            b = 5 * v;
                            f = regs[8'h14 + b];
                            f = f * 16 + regs[8'h13 + b];
                            f = f * 16 + regs[8'h12 + b];
                            f = f * 16 + regs[8'h11 + b];
                            f = (v == 0) ? f * 16 + regs[8'h10] : f * 16;
                            step[v]  = f[19:0];
                            level[v] = regs[8'h15 + b][3:0];
                            sel[v]   = regs[8'h05 + b][2:0];
                        end
                    end else begin
                        for (v = 0; v < n; v++) begin
                            b = 8 * v;
                            step[v]  = {regs[6 + b][3:0], regs[5 + b], regs[4 + b]};
                            level[v] = regs[3 + b][3:0];
                            sel[v]   = regs[6 + b][6:4];
                        end
                    end
                end
                FN_WAVE_WR: wave[addr] = data;
                FN_EN_WR:   sound_on = (data != 8'h00);
                FN_TICK: begin
                    sum = 0;
                    if (sound_on && n != 0) begin
                        for (v = 0; v < n; v++) begin
                            if (level[v] != 0 && step[v] != 0) begin
                                phase[v] = phase[v] + step[v];
                                idx = phase[v][19:15];
                                if (two_spb) begin
                                    wbyte = wave[{sel[v], 1'b0, idx[4:1]}];
                                    nib = idx[0] ? wbyte[3:0] : wbyte[7:4];
                                end else begin
                                    wbyte = wave[{sel[v], idx}];
                                    nib = wbyte[3:0];
                                end
                                sum += (int'(nib) - 8) * int'(level[v]);
                            end
                        end
                        // Scale the sum by 256 / n and saturate the magnitude.
                        mag = (sum < 0) ? -sum : sum;
                        mag = mag * 256 / n;
                        if (mag > 32767) mag = 32767;
                    end else begin
                        mag = 0;
                    end
                    res = (sum < 0) ? -int'(mag) : int'(mag);
                    expected_samples.push_back(res[15:0]);
                end
                default: ;
            endcase
        endfunction

        // Compare one strobed sample with the oldest prediction.
        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                $error("sample: expected none, got %0d", got);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("sample: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_func;
    logic [7:0]          i_addr;
    logic [7:0]          i_data;
    logic                o_strobe;
    logic signed [15:0]  o_sample;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    mix_scoreboard sb = new();
    int            cycle_cnt = 0;
    int            settings_cnt = 0;
    bit            gaps_on = 1'b1;
    logic          cur_layout = 1'b0;

    // Register settings of the random phases; the last one is drawn at run time.
    int unsigned   phase_count [PHASE_COUNT] = '{8, 8, 1, 3, 8, 2, 5, 1, 15, 8, 4, 0};
    bit            phase_layout [PHASE_COUNT] = '{1, 1, 1, 0, 0, 1, 1, 0, 1, 0, 1, 0};
    bit            phase_spb [PHASE_COUNT]    = '{0, 1, 0, 0, 1, 1, 0, 1, 1, 0, 1, 0};

    wavetable_sound_generator_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_func),
        .i_addr   (i_addr),
        .i_data   (i_data),
        .o_strobe (o_strobe),
        .o_sample (o_sample),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit in clock cycles.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[wavetable_sound_generator_core] ERROR");
            $finish;
        end
    end

    // Monitor: results first, then settings, then newly accepted commands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_sample(o_sample);
            if (psel && penable && pwrite && pready) sb.write_setting(paddr[3:2], pwdata);
            if (start && !busy) sb.note_command(t_func'(i_func), i_addr, i_data);
        end
    end

    // Present one command transaction and return at the edge that accepts it.
    task automatic send_command(t_func fn, logic [7:0] addr, logic [7:0] data);
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 21) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= fn;
        i_addr <= addr;
        i_data <= data;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Hold off the sender until every predicted sample has been seen.
    task automatic wait_for_samples();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_samples.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let the block go idle, then write all three settings.
    task automatic apply_setting(int unsigned count, bit lay, bit spb);
        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_VOICE_COUNT, {28'h0, count[3:0]});
        write_reg(CFG_LAYOUT, {31'h0, lay});
        write_reg(CFG_TWO_SPB, {31'h0, spb});
        cur_layout = lay;
        settings_cnt++;
    endtask

    // One random command, weighted toward voice registers and ticks.
    task automatic random_command();
        int         pick;
        logic [7:0] addr;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        addr = $urandom_range(0, 255);
        data = $urandom_range(0, 255);
        if (pick < 40) begin
            send_command(FN_TICK, addr, data);
        end else if (pick < 75) begin
            // Most register writes land on a field that some voice decodes.
            if ($urandom_range(0, 99) < 85) begin
                if (cur_layout)
                    addr[5:0] = {3'($urandom_range(0, 7)), 3'($urandom_range(3, 6))};
                else if ($urandom_range(0, 4) != 0)
                    addr[5:0] = 6'h10 + 6'($urandom_range(0, 15));
                else
                    addr[5:0] = 6'h05 + 6'(5 * $urandom_range(0, 2));
            end
            send_command(FN_REG_WR, addr, data);
        end else if (pick < 88) begin
            send_command(FN_WAVE_WR, addr, data);
        end else begin
            if ($urandom_range(0, 3) == 0) data = 8'h00;
            send_command(FN_EN_WR, addr, data);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_func  <= FN_REG_WR;
        i_addr  <= 8'h00;
        i_data  <= 8'h00;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'h0;
        pwdata  <= 32'h0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Byte layout first; fill the whole wave store so no tick reads an unwritten byte.
        apply_setting(8, 1'b1, 1'b0);
        for (int a = 0; a < 256; a++) send_command(FN_WAVE_WR, a[7:0], 8'($urandom_range(0, 255)));

        // Directed: voice 0 at full level and largest step (phase wraps), voice 7 at step one.
        send_command(FN_REG_WR, 8'hc3, 8'h0f);
        send_command(FN_REG_WR, 8'h44, 8'hff);
        send_command(FN_REG_WR, 8'h85, 8'hff);
        send_command(FN_REG_WR, 8'h06, 8'hff);
        send_command(FN_REG_WR, 8'h3b, 8'hff);
        send_command(FN_REG_WR, 8'h3c, 8'h01);
        send_command(FN_REG_WR, 8'hfd, 8'h00);
        send_command(FN_REG_WR, 8'h3e, 8'h00);
        repeat (3) send_command(FN_TICK, 8'hff, 8'hff);

        // Sound disabled gives zero and holds phases; then enabled again.
        send_command(FN_EN_WR, 8'h00, 8'h00);
        send_command(FN_TICK, 8'h00, 8'h00);
        send_command(FN_EN_WR, 8'hff, 8'h80);
        send_command(FN_TICK, 8'h00, 8'h00);

        // Zero voices mixes nothing.
        apply_setting(0, 1'b1, 1'b1);
        send_command(FN_TICK, 8'h55, 8'haa);

        // Oversized count saturates; nibble layout keeps only low nibbles and
        // voices it does not decode keep their byte-layout values.
        apply_setting(15, 1'b0, 1'b1);
        send_command(FN_REG_WR, 8'h10, 8'hff);
        send_command(FN_REG_WR, 8'h15, 8'h0f);
        send_command(FN_REG_WR, 8'h14, 8'h0f);
        repeat (2) send_command(FN_TICK, 8'haa, 8'h55);

        // Random phases, one register setting each; phase four runs without gaps.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p == PHASE_COUNT - 1)
                apply_setting($urandom_range(1, 8), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            else
                apply_setting(phase_count[p], phase_layout[p], phase_spb[p]);
            gaps_on = (p != 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_command();
                if ($urandom_range(0, 149) == 0) wait_for_samples();
            end
        end
        gaps_on = 1'b1;

        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.expected_samples.size() != 0) begin
            $error("sample: %0d predicted samples never arrived", sb.expected_samples.size());
            sb.errors++;
        end

        $display("Run covered %0d command transactions under %0d register settings,",
                 sb.n_items, settings_cnt);
        $display("with %0d mixed samples compared against prediction.", sb.n_checked);
        if (sb.errors == 0) begin
            $display("[wavetable_sound_generator_core] OK");
        end else begin
            $display("[wavetable_sound_generator_core] ERROR");
        end
        $finish;
    end

endmodule

>>> wavetable_sound_generator_core.f
hw/rtl/wsg_pkg.sv
hw/rtl/wsg_regs.sv
hw/rtl/wsg_voice.sv
hw/rtl/wsg_div.sv
hw/rtl/wavetable_sound_generator_core.sv
tb/tb.sv
